// ===== rtl/mbreq_pkg.sv =====
// Shared types and constants for the Modbus ASCII request framer.
// No dependencies; all framer modules reference this package by scoped names.
package mbreq_pkg;

  localparam int unsigned BytesMax = 12;

  localparam logic [1:0] ReqRead   = 2'd0;
  localparam logic [1:0] ReqWrite1 = 2'd1;
  localparam logic [1:0] ReqWrite2 = 2'd2;

  localparam logic [7:0] FnRead   = 8'h03;
  localparam logic [7:0] FnWrite1 = 8'h06;
  localparam logic [7:0] FnWrite2 = 8'h10;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChA     = 8'h41;

  localparam logic [4:0] LastPosShort = 5'd16;
  localparam logic [4:0] LastPosLong  = 5'd26;
  localparam logic [3:0] NumBinShort  = 4'd6;
  localparam logic [3:0] NumBinLong   = 4'd11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [15:0] register_count;
    logic [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_char;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic                     dbl;
    logic [BytesMax-1:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic       busy;
    logic [4:0] pos;
  } back_sts_t;

endpackage

// ===== rtl/mbreq_front.sv =====
// Front end: accepts requests, drops unused request types, lays out binary bytes.
// Depends on mbreq_pkg.
module mbreq_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mbreq_pkg::req_t in_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output mbreq_pkg::job_t push_data_o
);

  mbreq_pkg::job_t job;
  logic            known;

  always_comb begin
    job          = '0;
    known        = 1'b1;
    job.bytes[0] = in_data_i.slave_addr;
    job.bytes[2] = in_data_i.reg_addr[15:8];
    job.bytes[3] = in_data_i.reg_addr[7:0];
    job.bytes[4] = in_data_i.register_count[15:8];
    job.bytes[5] = in_data_i.register_count[7:0];
    unique case (in_data_i.req_type)
      mbreq_pkg::ReqRead: begin
        job.bytes[1] = mbreq_pkg::FnRead;
      end
      mbreq_pkg::ReqWrite1: begin
        job.bytes[1] = mbreq_pkg::FnWrite1;
        job.bytes[4] = in_data_i.data_value[15:8];
        job.bytes[5] = in_data_i.data_value[7:0];
      end
      mbreq_pkg::ReqWrite2: begin
        job.dbl       = 1'b1;
        job.bytes[1]  = mbreq_pkg::FnWrite2;
        job.bytes[6]  = {in_data_i.register_count[6:0], 1'b0};
        job.bytes[7]  = in_data_i.data_value[15:8];
        job.bytes[8]  = in_data_i.data_value[7:0];
        job.bytes[9]  = in_data_i.data_value[31:24];
        job.bytes[10] = in_data_i.data_value[23:16];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // drop unknown types on acceptance
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && known;
  assign push_data_o  = job;

endmodule

// ===== rtl/mbreq_fifo.sv =====
// Short job queue between the framer front and back ends.
// Depends on mbreq_pkg.
module mbreq_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mbreq_pkg::job_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mbreq_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mbreq_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mbreq_back.sv =====
// Back end: walks one job character by character, accumulates the LRC, drives output register.
// Depends on mbreq_pkg.
module mbreq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  mbreq_pkg::job_t       job_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mbreq_pkg::char_t      out_data_o,
  output mbreq_pkg::back_sts_t  sts_o
);

  mbreq_pkg::job_t  job_q, job_d;
  mbreq_pkg::char_t out_q, out_d;
  logic             busy_q, busy_d, out_valid_q, out_valid_d;
  logic [4:0]       pos_q, pos_d, pos_m1, last_pos;
  logic [7:0]       sum_q, sum_d, lrc, byte_sel, hex_char;
  logic [3:0]       byte_idx, nbin, nib;
  logic             emit, at_last, in_hex, pop;

  assign emit     = busy_q && (!out_valid_q || out_ready_i);
  assign last_pos = job_q.dbl ? mbreq_pkg::LastPosLong : mbreq_pkg::LastPosShort;
  assign nbin     = job_q.dbl ? mbreq_pkg::NumBinLong : mbreq_pkg::NumBinShort;
  assign at_last  = (pos_q == last_pos);
  assign in_hex   = (pos_q != '0) && (pos_q < (last_pos - 5'd1));
  assign pos_m1   = pos_q - 5'd1;
  assign byte_idx = pos_m1[4:1];
  assign lrc      = 8'(~sum_q + 8'd1);
  assign byte_sel = (byte_idx == nbin) ? lrc : job_q.bytes[byte_idx];
  assign nib      = pos_m1[0] ? byte_sel[3:0] : byte_sel[7:4];
  assign hex_char = (nib < 4'd10) ? (mbreq_pkg::ChZero + {4'd0, nib})
                                  : (mbreq_pkg::ChA + {4'd0, nib} - 8'd10);
  assign pop      = job_valid_i && (!busy_q || (emit && at_last));

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d = 1'b1;
      if (pos_q == '0) begin
        out_d = '{frame_char: mbreq_pkg::ChColon, last_char: 1'b0};
      end else if (at_last) begin
        out_d = '{frame_char: mbreq_pkg::ChLf, last_char: 1'b1};
      end else if (!in_hex) begin
        out_d = '{frame_char: mbreq_pkg::ChCr, last_char: 1'b0};
      end else begin
        out_d = '{frame_char: hex_char, last_char: 1'b0};
      end
      if (in_hex && pos_m1[0] && (byte_idx != nbin)) begin
        sum_d = sum_q + byte_sel;
      end
      if (at_last) begin
        pos_d  = '0;
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end
    if (pop) begin
      job_d  = job_data_i;
      busy_d = 1'b1;
      pos_d  = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign job_ready_o = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign sts_o       = '{busy: busy_q, pos: pos_q};

endmodule

// ===== rtl/modbus_ascii_request_framer.sv =====
// Modbus ASCII request framer top level: front end, job queue, character back end.
// Depends on mbreq_pkg, mbreq_front, mbreq_fifo, mbreq_back.
//
// Each accepted request becomes one Modbus ASCII frame on the output channel, one
// character per transaction: ':', the binary bytes as uppercase hex pairs, the LRC,
// then CR LF with last_char set on the LF. Read (03h) and single write (06h) frames
// have 17 characters, double writes (10h) have 27. The back end issues one character
// per cycle while out_ready_i does not stall it, and it takes the next queued request
// in the same cycle as it issues the LF. Request type 3 is accepted and dropped.
// QueueDepth (at least 2) requests can wait between front and back ends.
module modbus_ascii_request_framer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbreq_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbreq_pkg::char_t  out_data_o
);

  logic                 push_valid, push_ready, job_valid, job_ready;
  mbreq_pkg::job_t      push_data, job_data;
  mbreq_pkg::back_sts_t back_sts;

  mbreq_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mbreq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job_data)
  );

  mbreq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_data_i  (job_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .sts_o       (back_sts)
  );

`ifndef SYNTHESIS
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_char) |-> (out_data_o.frame_char == mbreq_pkg::ChLf))
    else $error("last_char set on a character other than LF");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.pos <= mbreq_pkg::LastPosLong)
    else $error("character position beyond frame length");

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_sts.busy |-> (back_sts.pos == '0))
    else $error("back end idle with nonzero position");

  a_pop_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && job_ready) |=> (back_sts.busy && back_sts.pos == '0))
    else $error("queued job did not start a new frame");
`endif

endmodule
